### rtl/core/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
package hbp_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int SYM_W         = 7;
  localparam int CODE_W        = 31;
  localparam int LEN_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int PEND_W        = BYTE_W - 1;
  localparam int PCNT_W        = 3;
  localparam int ACC_W         = CODE_W + PEND_W;
  localparam int TOT_W         = 6;
  localparam int WORD_W        = 40;
  localparam int OCNT_W        = 3;
  localparam int IN_DATA_W     = 48;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

### rtl/core/huffman_bit_packer_core.sv
// Huffman bit packer: code table, bit accumulator and byte output stage.
//
// Input words arrive on s_axis. tuser carries the action (load, encode,
// finish); tdata carries symbol, code value and code length. A load writes
// one code table entry. An encode appends the symbol's code MSB first to the
// bit accumulator; a finish appends the code of symbol 0, pads the last
// partial byte with zeros and empties the accumulator.
// Bytes leave on m_axis, one per cycle while m_axis_tready is high; tlast
// marks the final byte caused by one input word, tuser marks the final
// byte of a finished stream. The accepting edge loads the table read into
// the lookup stage, which moves the merged word into the output register
// once that register is empty or handing over its last byte. Throughput:
// one word per cycle when it yields at most one byte and m_axis_tready is
// high; otherwise the single-byte output port drains the merged word, up to
// five bytes for a finish.
// While a word is draining, the next word is held in the lookup stage, so
// a stalled receiver backs up into s_axis_tready after one word.
// Reset clears the per-entry valid bits (not the table contents), the
// accumulator and both pipeline stages.
module huffman_bit_packer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // symbol[6:0], code_value[37:7], code_length[42:38]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser   // stream_end[0]
);

  logic [hbp_pkg::SYM_W-1:0]  in_symbol;
  logic [hbp_pkg::CODE_W-1:0] in_code;
  logic [hbp_pkg::LEN_W-1:0]  in_len;
  hbp_pkg::action_t           in_action;
  logic                       accept;

  assign in_symbol = s_axis_tdata[6:0];
  assign in_code   = s_axis_tdata[37:7];
  assign in_len    = s_axis_tdata[42:38];
  assign in_action = hbp_pkg::action_t'(s_axis_tuser);
  assign accept    = s_axis_tvalid && s_axis_tready;

  // Code table memory and per-entry valid bits
  hbp_pkg::entry_t                   table_mem [hbp_pkg::TABLE_ENTRIES];
  logic [hbp_pkg::TABLE_ENTRIES-1:0] entry_valid;
  logic [hbp_pkg::TABLE_AW-1:0]      rd_addr;
  logic [hbp_pkg::CODE_W-1:0]        load_mask;
  logic                              is_load;
  logic                              is_work;

  always_comb begin
    is_load = 1'b0;
    is_work = 1'b0;
    rd_addr = in_symbol[hbp_pkg::TABLE_AW-1:0];
    case (in_action)
      hbp_pkg::ACT_LOAD: begin
        is_load = 1'b1;
      end
      hbp_pkg::ACT_ENCODE: begin
        is_work = 1'b1;
      end
      hbp_pkg::ACT_FINISH: begin
        is_work = 1'b1;
        rd_addr = '0;
      end
      default: begin
        is_load = 1'b0;
      end
    endcase
  end

  // A length of 31 wraps the shifted one to zero, giving all ones
  assign load_mask = (hbp_pkg::CODE_W'(1) << in_len) - hbp_pkg::CODE_W'(1);

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      table_mem[in_symbol[hbp_pkg::TABLE_AW-1:0]] <= '{code: in_code & load_mask, len: in_len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (accept && is_load) begin
      entry_valid[in_symbol[hbp_pkg::TABLE_AW-1:0]] <= 1'b1;
    end
  end

  // Lookup stage
  logic            s1_valid;
  logic            s1_finish;
  logic            s1_hit;
  hbp_pkg::entry_t s1_entry;
  logic            s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_work;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_entry  <= table_mem[rd_addr];
      s1_hit    <= entry_valid[rd_addr];
      s1_finish <= (in_action == hbp_pkg::ACT_FINISH);
    end
  end

  // Merge code into accumulator
  logic [hbp_pkg::PEND_W-1:0] pend_bits;
  logic [hbp_pkg::PCNT_W-1:0] pend_cnt;
  logic [hbp_pkg::PEND_W-1:0] pend_bits_next;
  logic [hbp_pkg::PCNT_W-1:0] pend_cnt_next;
  logic [hbp_pkg::LEN_W-1:0]  code_len;
  logic [hbp_pkg::CODE_W-1:0] code_bits;
  logic [hbp_pkg::ACC_W-1:0]  acc;
  logic [hbp_pkg::TOT_W-1:0]  total;
  logic [hbp_pkg::TOT_W-1:0]  align_shift;
  logic [hbp_pkg::WORD_W-1:0] merged_word;
  logic [2:0]                 rem_bits;
  logic [hbp_pkg::OCNT_W-1:0] merged_cnt;
  logic [hbp_pkg::BYTE_W-1:0] rem_mask;

  always_comb begin
    code_len    = s1_hit ? s1_entry.len : '0;
    code_bits   = s1_hit ? s1_entry.code : '0;
    acc         = (hbp_pkg::ACC_W'(pend_bits) << code_len) | hbp_pkg::ACC_W'(code_bits);
    total       = hbp_pkg::TOT_W'(pend_cnt) + hbp_pkg::TOT_W'(code_len);
    align_shift = hbp_pkg::TOT_W'(hbp_pkg::WORD_W) - total;
    merged_word = hbp_pkg::WORD_W'(acc) << align_shift;
    rem_bits    = total[2:0];
    rem_mask    = (hbp_pkg::BYTE_W'(1) << rem_bits) - hbp_pkg::BYTE_W'(1);
    merged_cnt  = hbp_pkg::OCNT_W'(total[hbp_pkg::TOT_W-1:3]);
    if (s1_finish) begin
      // pad the partial byte; it already sits zero-filled in the word
      if (rem_bits != 3'd0) begin
        merged_cnt = merged_cnt + hbp_pkg::OCNT_W'(1);
      end
      pend_bits_next = '0;
      pend_cnt_next  = '0;
    end else begin
      pend_bits_next = acc[hbp_pkg::PEND_W-1:0] & rem_mask[hbp_pkg::PEND_W-1:0];
      pend_cnt_next  = rem_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else if (s1_move) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  // Output register: drains the merged word one byte per cycle while m_axis_tready is high
  logic [hbp_pkg::WORD_W-1:0] out_word;
  logic [hbp_pkg::OCNT_W-1:0] out_cnt;
  logic                       out_fin;
  logic                       out_take;

  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign s1_move       = s1_valid &&
                         ((out_cnt == '0) ||
                          ((out_cnt == hbp_pkg::OCNT_W'(1)) && m_axis_tready));
  assign s_axis_tready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else if (s1_move) begin
      out_cnt <= merged_cnt;
    end else if (out_take) begin
      out_cnt <= out_cnt - hbp_pkg::OCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_word <= merged_word;
      out_fin  <= s1_finish;
    end else if (out_take) begin
      out_word <= out_word << hbp_pkg::BYTE_W;
    end
  end

  assign m_axis_tvalid = (out_cnt != '0);
  assign m_axis_tdata  = out_word[hbp_pkg::WORD_W-1 -: hbp_pkg::BYTE_W];
  assign m_axis_tlast  = (out_cnt == hbp_pkg::OCNT_W'(1));
  assign m_axis_tuser  = out_fin && (out_cnt == hbp_pkg::OCNT_W'(1));

  // Checks
  a_out_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= hbp_pkg::OCNT_W'(5))
    else $error("output byte count out of range");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_finish) |=> (pend_cnt == '0 && pend_bits == '0))
    else $error("accumulator not emptied by finish");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("stream end without last byte");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && out_cnt != '0))
    else $error("input stalled without pending work");

endmodule
